// ----- sv/dgram_pkg.sv -----
// shared types, constants and command/status structs for the depth gram accumulator
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package dgram_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int COL_W        = $clog2(FRAME_WIDTH);
  localparam int ROW_W        = $clog2(FRAME_HEIGHT);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

  // field widths
  localparam int DEPTH_W     = 16;
  localparam int SLOPE_W     = 17;
  localparam int TERM_W      = 64;
  localparam int NTERMS      = 6;
  localparam int NENTRIES    = 36;
  localparam int IDX_W       = 6;
  localparam int Q_SHIFT     = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 392;

  localparam logic [IDX_W-1:0]        LAST_ENTRY = IDX_W'(NENTRIES - 1);
  localparam logic [2:0]              LAST_TERM  = 3'(NTERMS - 1);
  localparam logic signed [TERM_W-1:0] NEG_ONE_Q = -(TERM_W'(64'sd1) <<< Q_SHIFT);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_Y = 2'd1;

  // shared multiplier and small products
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 40;
  localparam int PREP_STEPS = 11;
  localparam logic [3:0] PREP_LAST = 4'(PREP_STEPS - 1);

  // rounding divider
  localparam int DIV_W     = 45;
  localparam int DIV_LANES = 3;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int REM_W     = 17;

  typedef logic [DIV_W-1:0] dgram_dvd_t;

  // multiplier operations, prep products first in step order
  typedef enum logic [3:0] {
    MOP_SX_J, MOP_SY_I, MOP_I_D, MOP_I_I, MOP_J_J, MOP_SX_I, MOP_SY_J,
    MOP_M1_I, MOP_SY_M4, MOP_SX_M5, MOP_M7_I,
    MOP_A0B0, MOP_A0B1, MOP_A1B0, MOP_A1B1, MOP_NONE
  } dgram_mop_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_TERMS, S_DIV, S_PIX,
    S_G_ABS, S_G_P00, S_G_P01, S_G_P10, S_G_P11,
    S_G_MID, S_G_RND, S_G_CLAMP, S_G_ACC, S_RD, S_DUMP
  } dgram_state_t;

  typedef struct packed {
    logic             load;
    dgram_mop_t       mop;
    logic             terms;
    logic             div_take;
    logic             emit_pix;
    logic             g_abs;
    logic             g_mid;
    logic             g_rnd;
    logic             g_clamp;
    logic             g_acc;
    logic             g_adv;
    logic             row_wrap;
    logic             rd;
    logic             emit_gram;
    logic [IDX_W-1:0] entry;
  } dgram_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic frame_end;
  } dgram_sts_t;

endpackage

`default_nettype wire

// ----- sv/dgram_div.sv -----
// three-lane restoring divider, one quotient bit per lane per cycle
// depends on dgram_pkg
`default_nettype none

module dgram_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire dgram_pkg::dgram_dvd_t dividend [dgram_pkg::DIV_LANES],
  input  wire logic [dgram_pkg::REM_W-1:0] divisor,
  output logic                     done,
  output dgram_pkg::dgram_dvd_t    quotient [dgram_pkg::DIV_LANES]
);

  logic                             busy_r;
  logic                             done_r;
  logic [dgram_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [dgram_pkg::REM_W-1:0]      dsr_r;
  logic [dgram_pkg::REM_W-1:0]      rem_r [dgram_pkg::DIV_LANES];
  dgram_pkg::dgram_dvd_t            dvd_r [dgram_pkg::DIV_LANES];
  dgram_pkg::dgram_dvd_t            quo_r [dgram_pkg::DIV_LANES];

  logic [dgram_pkg::REM_W:0]        sh   [dgram_pkg::DIV_LANES];
  logic                             qbit [dgram_pkg::DIV_LANES];
  logic [dgram_pkg::REM_W-1:0]      rem_nxt [dgram_pkg::DIV_LANES];

  // trial subtract per lane
  always_comb begin
    for (int l = 0; l < dgram_pkg::DIV_LANES; l++) begin
      sh[l]   = {rem_r[l], dvd_r[l][dgram_pkg::DIV_W-1]};
      qbit[l] = sh[l] >= {1'b0, dsr_r};
      rem_nxt[l] = qbit[l] ? dgram_pkg::REM_W'(sh[l] - {1'b0, dsr_r})
                           : dgram_pkg::REM_W'(sh[l]);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= dgram_pkg::DIV_CNT_W'(dgram_pkg::DIV_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // lane data
  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= divisor;
      for (int l = 0; l < dgram_pkg::DIV_LANES; l++) begin
        rem_r[l] <= '0;
        dvd_r[l] <= dividend[l];
        quo_r[l] <= '0;
      end
    end else if (busy_r) begin
      for (int l = 0; l < dgram_pkg::DIV_LANES; l++) begin
        rem_r[l] <= rem_nxt[l];
        dvd_r[l] <= dvd_r[l] << 1;
        quo_r[l] <= {quo_r[l][dgram_pkg::DIV_W-2:0], qbit[l]};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- sv/dgram_ctrl.sv -----
// sequencer for pixel terms, gram accumulation and end-of-frame readout
// depends on dgram_pkg; drives the datapath through dgram_cmd_t
`default_nettype none

module dgram_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire dgram_pkg::dgram_sts_t sts,
  output dgram_pkg::dgram_cmd_t      cmd
);

  dgram_pkg::dgram_state_t        state_r, state_nxt;
  logic [3:0]                     step_r, step_nxt;
  logic [2:0]                     c_r, c_nxt;
  logic [dgram_pkg::IDX_W-1:0]    k_r, k_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dgram_pkg::S_IDLE;
      step_r  <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.mop   = dgram_pkg::MOP_NONE;
    cmd.entry = k_r;
    unique case (state_r)
      dgram_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = dgram_pkg::S_PREP;
        end
      end
      dgram_pkg::S_PREP: begin
        cmd.mop = dgram_pkg::dgram_mop_t'(step_r);
        if (step_r == dgram_pkg::PREP_LAST) state_nxt = dgram_pkg::S_TERMS;
        else step_nxt = step_r + 1'b1;
      end
      dgram_pkg::S_TERMS: begin
        cmd.terms = 1'b1;
        state_nxt = dgram_pkg::S_DIV;
      end
      dgram_pkg::S_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = dgram_pkg::S_PIX;
        end
      end
      dgram_pkg::S_PIX: begin
        if (sts.out_free) begin
          cmd.emit_pix = 1'b1;
          c_nxt        = '0;
          k_nxt        = '0;
          state_nxt    = dgram_pkg::S_G_ABS;
        end
      end
      dgram_pkg::S_G_ABS: begin
        cmd.g_abs = 1'b1;
        state_nxt = dgram_pkg::S_G_P00;
      end
      dgram_pkg::S_G_P00: begin
        cmd.mop   = dgram_pkg::MOP_A0B0;
        state_nxt = dgram_pkg::S_G_P01;
      end
      dgram_pkg::S_G_P01: begin
        cmd.mop   = dgram_pkg::MOP_A0B1;
        state_nxt = dgram_pkg::S_G_P10;
      end
      dgram_pkg::S_G_P10: begin
        cmd.mop   = dgram_pkg::MOP_A1B0;
        state_nxt = dgram_pkg::S_G_P11;
      end
      dgram_pkg::S_G_P11: begin
        cmd.mop   = dgram_pkg::MOP_A1B1;
        state_nxt = dgram_pkg::S_G_MID;
      end
      dgram_pkg::S_G_MID: begin
        cmd.g_mid = 1'b1;
        state_nxt = dgram_pkg::S_G_RND;
      end
      dgram_pkg::S_G_RND: begin
        cmd.g_rnd = 1'b1;
        state_nxt = dgram_pkg::S_G_CLAMP;
      end
      dgram_pkg::S_G_CLAMP: begin
        cmd.g_clamp = 1'b1;
        state_nxt   = dgram_pkg::S_G_ACC;
      end
      dgram_pkg::S_G_ACC: begin
        cmd.g_acc    = 1'b1;
        cmd.g_adv    = 1'b1;
        cmd.row_wrap = c_r == dgram_pkg::LAST_TERM;
        c_nxt        = (c_r == dgram_pkg::LAST_TERM) ? '0 : c_r + 1'b1;
        if (k_r == dgram_pkg::LAST_ENTRY) begin
          k_nxt     = '0;
          state_nxt = sts.frame_end ? dgram_pkg::S_RD : dgram_pkg::S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = dgram_pkg::S_G_ABS;
        end
      end
      dgram_pkg::S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = dgram_pkg::S_DUMP;
      end
      dgram_pkg::S_DUMP: begin
        if (sts.out_free) begin
          cmd.emit_gram = 1'b1;
          if (k_r == dgram_pkg::LAST_ENTRY) begin
            k_nxt     = '0;
            state_nxt = dgram_pkg::S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = dgram_pkg::S_RD;
          end
        end
      end
      default: state_nxt = dgram_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/dgram_dp.sv -----
// datapath: position counters, slopes, shared multiplier, terms, gram memory, output register
// depends on dgram_pkg and dgram_div; steered by dgram_cmd_t from the controller
`default_nettype none

module dgram_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [dgram_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                              cfg_valid,
  input  wire logic [dgram_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dgram_pkg::SLOPE_W-1:0]     cfg_data,
  input  wire dgram_pkg::dgram_cmd_t             cmd,
  output dgram_pkg::dgram_sts_t                  sts,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [dgram_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                   out_tuser,
  output logic                                   out_tlast
);

  localparam int SW = dgram_pkg::SLOPE_W;
  localparam int TW = dgram_pkg::TERM_W;
  localparam int PW = dgram_pkg::PROD_W;
  localparam int MW = dgram_pkg::MUL_W;

  // configuration and position state
  logic signed [SW-1:0]                init_x_r, init_y_r;
  logic signed [SW-1:0]                held_x_r, held_y_r;
  logic [dgram_pkg::COL_W-1:0]         col_r;
  logic [dgram_pkg::ROW_W-1:0]         row_r;
  logic [dgram_pkg::COL_W-1:0]         j_r;
  logic [dgram_pkg::ROW_W-1:0]         i_r;
  logic [dgram_pkg::DEPTH_W-1:0]       d_r;
  logic signed [SW-1:0]                sx_r, sy_r;
  logic                                frame_end_r;

  logic [dgram_pkg::DEPTH_W-1:0]       in_d, in_dr, in_db;
  logic                                first_px, last_col, last_row;
  logic signed [SW-1:0]                diff_x, diff_y, sx_new, sy_new;

  assign in_d  = in_tdata[15:0];
  assign in_dr = in_tdata[31:16];
  assign in_db = in_tdata[47:32];

  assign first_px = (col_r == '0) && (row_r == '0);
  assign last_col = col_r == dgram_pkg::COL_LAST;
  assign last_row = row_r == dgram_pkg::ROW_LAST;
  assign diff_x   = $signed({1'b0, in_dr}) - $signed({1'b0, in_d});
  assign diff_y   = $signed({1'b0, in_db}) - $signed({1'b0, in_d});
  assign sx_new   = last_col ? (first_px ? init_x_r : held_x_r) : diff_x;
  assign sy_new   = last_row ? (first_px ? init_y_r : held_y_r) : diff_y;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_x_r <= '0;
      init_y_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == dgram_pkg::CFG_SLOPE_X) init_x_r <= cfg_data;
      if (cfg_index == dgram_pkg::CFG_SLOPE_Y) init_y_r <= cfg_data;
    end
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.load) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r         <= in_d;
      j_r         <= col_r;
      i_r         <= row_r;
      sx_r        <= sx_new;
      sy_r        <= sy_new;
      held_x_r    <= sx_new;
      held_y_r    <= sy_new;
      frame_end_r <= last_col && last_row;
    end
  end

  // shared multiplier
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;
  logic signed [PW-1:0]   m_r [dgram_pkg::PREP_STEPS];
  logic [TW-1:0]          ua_r, ub_r;
  logic                   neg_r;

  always_comb begin
    unique case (cmd.mop)
      dgram_pkg::MOP_SX_J:  begin mul_a = MW'(sx_r);   mul_b = MW'(j_r); end
      dgram_pkg::MOP_SY_I:  begin mul_a = MW'(sy_r);   mul_b = MW'(i_r); end
      dgram_pkg::MOP_I_D:   begin mul_a = MW'(i_r);    mul_b = MW'(d_r); end
      dgram_pkg::MOP_I_I:   begin mul_a = MW'(i_r);    mul_b = MW'(i_r); end
      dgram_pkg::MOP_J_J:   begin mul_a = MW'(j_r);    mul_b = MW'(j_r); end
      dgram_pkg::MOP_SX_I:  begin mul_a = MW'(sx_r);   mul_b = MW'(i_r); end
      dgram_pkg::MOP_SY_J:  begin mul_a = MW'(sy_r);   mul_b = MW'(j_r); end
      dgram_pkg::MOP_M1_I:  begin mul_a = MW'(m_r[0]); mul_b = MW'(i_r); end
      dgram_pkg::MOP_SY_M4: begin mul_a = MW'(sy_r);   mul_b = MW'(m_r[3]) + MW'(1); end
      dgram_pkg::MOP_SX_M5: begin mul_a = MW'(sx_r);   mul_b = MW'(m_r[4]) + MW'(1); end
      dgram_pkg::MOP_M7_I:  begin mul_a = MW'(m_r[6]); mul_b = MW'(i_r); end
      dgram_pkg::MOP_A0B0:  begin mul_a = MW'(ua_r[31:0]);  mul_b = MW'(ub_r[31:0]);  end
      dgram_pkg::MOP_A0B1:  begin mul_a = MW'(ua_r[31:0]);  mul_b = MW'(ub_r[63:32]); end
      dgram_pkg::MOP_A1B0:  begin mul_a = MW'(ua_r[63:32]); mul_b = MW'(ub_r[31:0]);  end
      dgram_pkg::MOP_A1B1:  begin mul_a = MW'(ua_r[63:32]); mul_b = MW'(ub_r[63:32]); end
      dgram_pkg::MOP_NONE:  begin mul_a = '0; mul_b = '0; end
      default:              begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // product registers
  logic [TW-1:0] p00_r, p01_r, p10_r, p11_r;

  always_ff @(posedge clk) begin
    if (cmd.mop <= dgram_pkg::MOP_M7_I) m_r[cmd.mop] <= PW'(mul_p);
    if (cmd.mop == dgram_pkg::MOP_A0B0) p00_r <= mul_p[TW-1:0];
    if (cmd.mop == dgram_pkg::MOP_A0B1) p01_r <= mul_p[TW-1:0];
    if (cmd.mop == dgram_pkg::MOP_A1B0) p10_r <= mul_p[TW-1:0];
    if (cmd.mop == dgram_pkg::MOP_A1B1) p11_r <= mul_p[TW-1:0];
  end

  // exact terms and divider numerators
  logic signed [PW-1:0] t3s, t4s, t5s, n2s;
  logic [SW-1:0]        magx, magy;
  logic [PW-1:0]        mag2;
  dgram_pkg::dgram_dvd_t div_dvd [dgram_pkg::DIV_LANES];
  dgram_pkg::dgram_dvd_t div_quo [dgram_pkg::DIV_LANES];
  logic                 div_done;
  logic                 dneg_r [dgram_pkg::DIV_LANES];

  assign t3s  = m_r[8] - m_r[2] - m_r[7];
  assign t4s  = m_r[2] + m_r[9] + m_r[10];
  assign t5s  = m_r[6] - m_r[5];
  assign n2s  = m_r[0] + m_r[1];
  assign magx = sx_r[SW-1] ? SW'(-sx_r) : SW'(sx_r);
  assign magy = sy_r[SW-1] ? SW'(-sy_r) : SW'(sy_r);
  assign mag2 = n2s[PW-1] ? PW'(-n2s) : PW'(n2s);

  // dividend is 2*|n|*65536 + d so the floor gives round-half-away
  assign div_dvd[0] = (dgram_pkg::DIV_W'(magx) << (dgram_pkg::Q_SHIFT + 1))
                      + dgram_pkg::DIV_W'(d_r);
  assign div_dvd[1] = (dgram_pkg::DIV_W'(magy) << (dgram_pkg::Q_SHIFT + 1))
                      + dgram_pkg::DIV_W'(d_r);
  assign div_dvd[2] = (dgram_pkg::DIV_W'(mag2) << (dgram_pkg::Q_SHIFT + 1))
                      + dgram_pkg::DIV_W'(d_r);

  dgram_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.terms),
    .dividend (div_dvd),
    .divisor  ({d_r, 1'b0}),
    .done     (div_done),
    .quotient (div_quo)
  );

  // signed quotients
  logic signed [TW-1:0] qv [dgram_pkg::DIV_LANES];

  always_comb begin
    for (int l = 0; l < dgram_pkg::DIV_LANES; l++) begin
      qv[l] = $signed(TW'(div_quo[l]));
      if (dneg_r[l]) qv[l] = -qv[l];
      if (d_r == '0) qv[l] = '0;
    end
  end

  // term rotators: row copy steps per row, column copy steps per entry
  logic signed [TW-1:0] trow_r [dgram_pkg::NTERMS];
  logic signed [TW-1:0] tcol_r [dgram_pkg::NTERMS];

  always_ff @(posedge clk) begin
    if (cmd.terms) begin
      dneg_r[0] <= sx_r[SW-1];
      dneg_r[1] <= sy_r[SW-1];
      dneg_r[2] <= n2s[PW-1];
      trow_r[3] <= TW'(t3s) <<< dgram_pkg::Q_SHIFT;
      trow_r[4] <= TW'(t4s) <<< dgram_pkg::Q_SHIFT;
      trow_r[5] <= TW'(t5s) <<< dgram_pkg::Q_SHIFT;
      tcol_r[3] <= TW'(t3s) <<< dgram_pkg::Q_SHIFT;
      tcol_r[4] <= TW'(t4s) <<< dgram_pkg::Q_SHIFT;
      tcol_r[5] <= TW'(t5s) <<< dgram_pkg::Q_SHIFT;
    end else if (cmd.div_take) begin
      trow_r[0] <= qv[0];
      trow_r[1] <= qv[1];
      trow_r[2] <= dgram_pkg::NEG_ONE_Q - qv[2];
      tcol_r[0] <= qv[0];
      tcol_r[1] <= qv[1];
      tcol_r[2] <= dgram_pkg::NEG_ONE_Q - qv[2];
    end else if (cmd.g_adv) begin
      for (int n = 0; n < dgram_pkg::NTERMS - 1; n++) tcol_r[n] <= tcol_r[n+1];
      tcol_r[dgram_pkg::NTERMS-1] <= tcol_r[0];
      if (cmd.row_wrap) begin
        for (int n = 0; n < dgram_pkg::NTERMS - 1; n++) trow_r[n] <= trow_r[n+1];
        trow_r[dgram_pkg::NTERMS-1] <= trow_r[0];
      end
    end
  end

  // gram product: magnitudes, partial sums, rounding, clamp
  logic [33:0]          mid_r;
  logic [TW-1:0]        hip_r, r_r, prod_mag;
  logic                 big_r, psat_r;
  logic signed [TW-1:0] prod_r;
  logic [TW:0]          lo2;
  logic [TW-1:0]        hi, limit;
  logic                 over;

  assign lo2      = {1'b0, mid_r[31:0], p00_r[31:0]} + 65'h8000;
  assign hi       = hip_r + TW'(mid_r[33:32]) + TW'(lo2[TW]);
  assign limit    = neg_r ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
  assign over     = big_r || (r_r > limit);
  assign prod_mag = over ? limit : r_r;

  always_ff @(posedge clk) begin
    if (cmd.g_abs) begin
      ua_r  <= trow_r[0][TW-1] ? TW'(-trow_r[0]) : TW'(trow_r[0]);
      ub_r  <= tcol_r[0][TW-1] ? TW'(-tcol_r[0]) : TW'(tcol_r[0]);
      neg_r <= trow_r[0][TW-1] ^ tcol_r[0][TW-1];
    end
    if (cmd.g_mid) begin
      mid_r <= 34'(p00_r[63:32]) + 34'(p01_r[31:0]) + 34'(p10_r[31:0]);
      hip_r <= p11_r + TW'(p01_r[63:32]) + TW'(p10_r[63:32]);
    end
    if (cmd.g_rnd) begin
      r_r   <= {hi[15:0], lo2[63:16]};
      big_r <= |hi[63:16];
    end
    if (cmd.g_clamp) begin
      prod_r <= neg_r ? $signed(-prod_mag) : $signed(prod_mag);
      psat_r <= over;
    end
  end

  // gram accumulator memory with per-entry valid bits and saturation marks
  logic [TW-1:0]                  acc_mem [dgram_pkg::NENTRIES];
  logic [dgram_pkg::NENTRIES-1:0] vld_r, mark_r;
  logic [TW-1:0]                  rd_r;
  logic                           rdv_r;
  logic signed [TW-1:0]           acc_in, acc_sum, acc_new;
  logic                           add_sat;

  assign acc_in  = rdv_r ? $signed(rd_r) : '0;
  assign acc_sum = acc_in + prod_r;

  always_comb begin
    add_sat = 1'b0;
    acc_new = acc_sum;
    if (!acc_in[TW-1] && !prod_r[TW-1] && acc_sum[TW-1]) begin
      add_sat = 1'b1;
      acc_new = 64'sh7fff_ffff_ffff_ffff;
    end else if (acc_in[TW-1] && prod_r[TW-1] && !acc_sum[TW-1]) begin
      add_sat = 1'b1;
      acc_new = 64'sh8000_0000_0000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.g_abs || cmd.rd) rd_r <= acc_mem[cmd.entry];
    if (cmd.g_acc) acc_mem[cmd.entry] <= acc_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      mark_r <= '0;
      rdv_r  <= 1'b0;
    end else begin
      if (cmd.g_abs || cmd.rd) rdv_r <= vld_r[cmd.entry];
      if (cmd.g_acc) begin
        vld_r[cmd.entry] <= 1'b1;
        if (psat_r || add_sat) mark_r[cmd.entry] <= 1'b1;
      end
      if (cmd.emit_gram) begin
        vld_r[cmd.entry]  <= 1'b0;
        mark_r[cmd.entry] <= 1'b0;
      end
    end
  end

  // output register
  logic                               out_valid_r;
  logic [dgram_pkg::OUT_TDATA_W-1:0]  out_data_r;
  logic                               out_kind_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_pix || cmd.emit_gram) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pix) begin
      out_data_r <= {1'b0, d_r == '0, {dgram_pkg::IDX_W{1'b0}},
                     trow_r[5], trow_r[4], trow_r[3], trow_r[2], trow_r[1], trow_r[0]};
      out_kind_r <= 1'b0;
      out_last_r <= !frame_end_r;
    end else if (cmd.emit_gram) begin
      out_data_r <= {mark_r[cmd.entry], 1'b0, cmd.entry, {(5*TW){1'b0}},
                     (rdv_r ? rd_r : {TW{1'b0}})};
      out_kind_r <= 1'b1;
      out_last_r <= cmd.entry == dgram_pkg::LAST_ENTRY;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tuser     = out_kind_r;
  assign out_tlast     = out_last_r;
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.div_done  = div_done;
  assign sts.frame_end = frame_end_r;

`ifndef NO_ASSERTIONS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_pix || cmd.emit_gram) |-> sts.out_free)
    else $error("result loaded while output register still full");

  a_take_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_take |-> div_done)
    else $error("quotients taken before divider finished");

  a_mark_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (mark_r & ~vld_r) == '0)
    else $error("saturation mark on an entry that holds no sum");

  a_counters_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= dgram_pkg::COL_LAST) && (row_r <= dgram_pkg::ROW_LAST))
    else $error("raster counter outside frame");
`endif

endmodule

`default_nettype wire

// ----- sv/depth_interaction_gram_accumulator.sv -----
// Pixel row valid once the taken pixel request has passed the prep products, the terms
// and the divider (one quotient bit per cycle); the next pixel is taken once the 36 gram
// entries of the last have passed through one 33x33 multiplier, later if the row waits
// on the output. The frame's last pixel adds 36 entry results, each waiting on the output.
// Reset (sync, active low) clears control, counters, config, valid bits and marks;
// no clearing pass, the block takes a request on the first cycle after reset.
// top level: joins the controller and datapath, depends on dgram_pkg, dgram_ctrl, dgram_dp
`default_nettype none

module depth_interaction_gram_accumulator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // tdata: depth[15:0], depth_right[31:16], depth_below[47:32]
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [dgram_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tdata: comp0..comp5 [383:0] (64 bits each), entry_index[389:384],
  //        zero_depth[390], saturated[391]
  // tuser: kind
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [dgram_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                   out_tuser,
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dgram_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dgram_pkg::SLOPE_W-1:0]     cfg_data
);

  dgram_pkg::dgram_cmd_t cmd;
  dgram_pkg::dgram_sts_t sts;

  // config registers are always writable
  assign cfg_ready = 1'b1;

  dgram_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dgram_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
